>>> hdl/rgbfade_pkg.sv
// Shared types, widths and constants for the RGB LED breathing fade encoder.
// Depends on nothing; imported by the controller, the datapath and the top level.
package rgbfade_pkg;

   localparam int LEVEL_WIDTH      = 16;
   localparam int TICK_COUNT_WIDTH = 20;
   localparam int COLOR_WIDTH      = 24;
   localparam int CHAN_WIDTH       = 8;
   localparam int PROD_WIDTH       = LEVEL_WIDTH + CHAN_WIDTH;
   localparam int DATA_WIDTH       = 3 * CHAN_WIDTH;
   localparam int LINE_WIDTH       = 3 * DATA_WIDTH;
   localparam int FRAME_BYTES      = LINE_WIDTH / 8;
   localparam int DIV_STEPS        = CHAN_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = COLOR_WIDTH;

   localparam logic [2:0] LINE_ONE  = 3'b110;
   localparam logic [2:0] LINE_ZERO = 3'b100;
   localparam logic [CHAN_WIDTH-1:0] CHAN_MAX = '1;

   localparam logic [COLOR_WIDTH-1:0]      IDLE_COLOR_RESET = 24'hFFFF00;
   localparam logic [LEVEL_WIDTH-1:0]      RAMP_STEPS_RESET = LEVEL_WIDTH'(256);
   localparam logic [TICK_COUNT_WIDTH-1:0] STEP_TICKS_RESET = TICK_COUNT_WIDTH'(500);
   localparam logic [TICK_COUNT_WIDTH-1:0] HOLD_TICKS_RESET = TICK_COUNT_WIDTH'(5000);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IDLE_COLOR = 2'd0,
      CSR_RAMP_STEPS = 2'd1,
      CSR_STEP_TICKS = 2'd2,
      CSR_HOLD_TICKS = 2'd3
   } csr_index_type;

   // Channel order on the wire: green, red, blue.
   typedef enum logic [1:0] {
      CH_GREEN = 2'd0,
      CH_RED   = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   typedef struct packed {
      logic     tick;      // evaluate pattern for the accepted transaction
      logic     mul;       // form level * color of the selected channel
      logic     div_step;  // one restoring-division step
      logic     div_last;  // store the saturated quotient
      logic     pack;      // expand the frame into line code
      logic     pop;       // advance to the next output byte
      chan_type chan;
   } cmd_type;

   typedef struct packed {
      logic frame_go;      // the pending transaction starts a frame
   } status_type;

   // Each data bit becomes three line bits, MSB first.
   function automatic logic [LINE_WIDTH-1:0] line_encode(input logic [DATA_WIDTH-1:0] data);
      logic [LINE_WIDTH-1:0] line;
      line = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         line[3*i +: 3] = data[i] ? LINE_ONE : LINE_ZERO;
      end
      return line;
   endfunction

endpackage

>>> hdl/rgbfade_ctrl.sv
// Controller state machine for the breathing fade encoder.
// Depends on rgbfade_pkg; drives commands into rgbfade_datapath.
module rgbfade_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_frame_last,
   input  rgbfade_pkg::status_type status,
   output rgbfade_pkg::cmd_type   cmd
);
   import rgbfade_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_PACK,
      ST_SEND
   } state_type;

   localparam int STEP_CNT_WIDTH = $clog2(DIV_STEPS);
   localparam int BYTE_CNT_WIDTH = $clog2(FRAME_BYTES);

   state_type                 state_ff;
   chan_type                  chan_ff;
   logic [STEP_CNT_WIDTH-1:0] step_ff;
   logic [BYTE_CNT_WIDTH-1:0] byte_ff;
   logic                      req_fire;
   logic                      rsp_fire;
   logic                      step_last;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_SEND);
   assign rsp_frame_last = (byte_ff == BYTE_CNT_WIDTH'(FRAME_BYTES - 1));
   assign req_fire       = req_valid && req_ready;
   assign rsp_fire       = rsp_valid && rsp_ready;
   assign step_last      = (step_ff == STEP_CNT_WIDTH'(DIV_STEPS - 1));

   always_comb begin
      cmd          = '0;
      cmd.chan     = chan_ff;
      cmd.tick     = req_fire;
      cmd.mul      = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_last = (state_ff == ST_DIV) && step_last;
      cmd.pack     = (state_ff == ST_PACK);
      cmd.pop      = rsp_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= CH_GREEN;
         step_ff  <= '0;
         byte_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && status.frame_go) begin
                  chan_ff  <= CH_GREEN;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (step_last) begin
                  unique case (chan_ff)
                     CH_GREEN: begin
                        chan_ff  <= CH_RED;
                        state_ff <= ST_MUL;
                     end
                     CH_RED: begin
                        chan_ff  <= CH_BLUE;
                        state_ff <= ST_MUL;
                     end
                     default: state_ff <= ST_PACK;
                  endcase
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_PACK: begin
               byte_ff  <= '0;
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_fire) begin
                  if (rsp_frame_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     byte_ff <= byte_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/rgbfade_datapath.sv
// Datapath of the breathing fade encoder: config registers, pattern state,
// multiplier, restoring divider and line-code shifter. Depends on rgbfade_pkg.
module rgbfade_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [rgbfade_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rgbfade_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                  req_run,
   input  rgbfade_pkg::cmd_type                  cmd,
   output rgbfade_pkg::status_type               status,
   output logic [7:0]                            rsp_line_byte
);
   import rgbfade_pkg::*;

   typedef enum logic [1:0] {
      PH_UP        = 2'd0,
      PH_HOLD_UP   = 2'd1,
      PH_DOWN      = 2'd2,
      PH_HOLD_DOWN = 2'd3
   } phase_type;

   logic [COLOR_WIDTH-1:0]      idle_color_ff;
   logic [LEVEL_WIDTH-1:0]      ramp_steps_ff;
   logic [TICK_COUNT_WIDTH-1:0] step_ticks_ff;
   logic [TICK_COUNT_WIDTH-1:0] hold_ticks_ff;

   phase_type                   phase_ff, phase_in;
   logic [LEVEL_WIDTH-1:0]      level_ff, level_in;
   logic [TICK_COUNT_WIDTH-1:0] wait_ff, wait_in;
   logic [LEVEL_WIDTH-1:0]      frame_lvl_ff, frame_lvl_in;

   logic [PROD_WIDTH-1:0]       rem_ff;
   logic [PROD_WIDTH-1:0]       div_ff;
   logic [DIV_STEPS-1:0]        quo_ff;
   logic [DATA_WIDTH-1:0]       data_ff;
   logic [LINE_WIDTH-1:0]       line_ff;

   logic [LEVEL_WIDTH-1:0]      eff_steps;
   logic [TICK_COUNT_WIDTH-1:0] step_reload;
   logic [CHAN_WIDTH-1:0]       color_sel;
   logic                        rem_ge;
   logic [DIV_STEPS-1:0]        quo_next;
   logic [CHAN_WIDTH-1:0]       chan_value;
   logic                        is_hold;

   assign eff_steps   = (ramp_steps_ff == '0) ? LEVEL_WIDTH'(1) : ramp_steps_ff;
   assign step_reload = (step_ticks_ff == '0) ? '0 : step_ticks_ff - 1'b1;
   assign is_hold     = (phase_ff == PH_HOLD_UP) || (phase_ff == PH_HOLD_DOWN);

   assign status.frame_go = req_run && (wait_ff == '0) && (!is_hold || hold_ticks_ff == '0);

   // Pattern sequencing for one tick.
   always_comb begin
      phase_type                ph;
      logic [LEVEL_WIDTH-1:0]   lv;
      logic [LEVEL_WIDTH:0]     lv_inc;
      ph           = phase_ff;
      lv           = level_ff;
      lv_inc       = '0;
      phase_in     = phase_ff;
      level_in     = level_ff;
      wait_in      = wait_ff;
      frame_lvl_in = frame_lvl_ff;
      if (!req_run) begin
         phase_in = PH_UP;
         level_in = '0;
         wait_in  = '0;
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - 1'b1;
      end else begin
         if (is_hold) begin
            ph = (phase_ff == PH_HOLD_UP) ? PH_DOWN : PH_UP;
            lv = (ph == PH_DOWN) ? eff_steps : '0;
         end
         if (is_hold && hold_ticks_ff != '0) begin
            phase_in = ph;
            level_in = lv;
            wait_in  = hold_ticks_ff - 1'b1;
         end else begin
            frame_lvl_in = lv;
            wait_in      = step_reload;
            if (ph == PH_UP) begin
               lv_inc   = {1'b0, lv} + 1'b1;
               level_in = lv_inc[LEVEL_WIDTH-1:0];
               phase_in = (lv_inc >= {1'b0, eff_steps}) ? PH_HOLD_UP : PH_UP;
            end else if (lv <= LEVEL_WIDTH'(1)) begin
               level_in = '0;
               phase_in = PH_HOLD_DOWN;
            end else begin
               level_in = lv - 1'b1;
               phase_in = PH_DOWN;
            end
         end
      end
   end

   always_comb begin
      unique case (cmd.chan)
         CH_GREEN: color_sel = idle_color_ff[15:8];
         CH_RED:   color_sel = idle_color_ff[23:16];
         CH_BLUE:  color_sel = idle_color_ff[7:0];
         default:  color_sel = '0;
      endcase
   end

   // Quotient bit 8 set means the level overran the steps: saturate.
   assign rem_ge     = (rem_ff >= div_ff);
   assign quo_next   = {quo_ff[DIV_STEPS-2:0], rem_ge};
   assign chan_value = quo_next[DIV_STEPS-1] ? CHAN_MAX : quo_next[CHAN_WIDTH-1:0];

   assign rsp_line_byte = line_ff[LINE_WIDTH-1 -: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_color_ff <= IDLE_COLOR_RESET;
         ramp_steps_ff <= RAMP_STEPS_RESET;
         step_ticks_ff <= STEP_TICKS_RESET;
         hold_ticks_ff <= HOLD_TICKS_RESET;
         phase_ff      <= PH_UP;
         level_ff      <= '0;
         wait_ff       <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_IDLE_COLOR: idle_color_ff <= csr_data[COLOR_WIDTH-1:0];
               CSR_RAMP_STEPS: ramp_steps_ff <= csr_data[LEVEL_WIDTH-1:0];
               CSR_STEP_TICKS: step_ticks_ff <= csr_data[TICK_COUNT_WIDTH-1:0];
               CSR_HOLD_TICKS: hold_ticks_ff <= csr_data[TICK_COUNT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (cmd.tick) begin
            phase_ff <= phase_in;
            level_ff <= level_in;
            wait_ff  <= wait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         frame_lvl_ff <= frame_lvl_in;
      end
      if (cmd.mul) begin
         rem_ff <= {{CHAN_WIDTH{1'b0}}, frame_lvl_ff} * {{LEVEL_WIDTH{1'b0}}, color_sel};
         div_ff <= {eff_steps, {CHAN_WIDTH{1'b0}}};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - div_ff;
         end
         div_ff <= div_ff >> 1;
         quo_ff <= quo_next;
      end
      if (cmd.div_last) begin
         data_ff <= {data_ff[DATA_WIDTH-CHAN_WIDTH-1:0], chan_value};
      end
      if (cmd.pack) begin
         line_ff <= line_encode(data_ff);
      end else if (cmd.pop) begin
         line_ff <= {line_ff[LINE_WIDTH-9:0], 8'h00};
      end
   end

endmodule

>>> hdl/rgb_led_breathing_fade_encoder_core.sv
// Top level of the RGB LED breathing fade encoder.
// Depends on rgbfade_pkg, rgbfade_ctrl and rgbfade_datapath.
//
//   Channel  Ports                                   Direction  Meaning
//   req      req_valid/req_ready, req_run            in         one microsecond tick
//   rsp      rsp_valid/rsp_ready, rsp_line_byte,     out        line-code bytes, nine
//            rsp_frame_last                                     per frame
//   csr      csr_valid/csr_ready, csr_index,         in         register writes
//            csr_data
//
// A tick that starts no frame leaves the controller idle. A tick that starts a frame
// is accepted, then runs the arithmetic (per channel one multiply and nine division
// steps of the shared divider, then one packing step) and then sends the nine output
// bytes, which rsp stalls hold back.
// Reset is synchronous and restores the registers and the pattern state.
// The next tick is taken only after the last byte of a frame has gone out.
module rgb_led_breathing_fade_encoder_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_run,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_line_byte,
   output logic                                   rsp_frame_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rgbfade_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rgbfade_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import rgbfade_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Registers accept a write at any time; software must write only while idle.
   assign csr_ready = 1'b1;

   // Sequence the tick, the three channel divisions and the byte drain.
   rgbfade_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_last (rsp_frame_last),
      .status         (status),
      .cmd            (cmd)
   );

   // Hold the pattern state, compute channel levels and shift out line code.
   rgbfade_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_run       (req_run),
      .cmd           (cmd),
      .status        (status),
      .rsp_line_byte (rsp_line_byte)
   );

endmodule
